/* rtl/qte_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// qte_pkg: shared types and constants of the quaternion to Euler angle unit
// Holds the data types that travel between the cells, the CORDIC angle table
// and the rounding function used at the output.
// ----------------------------------------------------------------------------
package qte_pkg;

    // Number of CORDIC rotations, limited to the size of the angle table.
    localparam int CORDIC_STEPS = 16;
    localparam int ANG_TAB_LEN  = 24;
    localparam int N_ITER = (CORDIC_STEPS < ANG_TAB_LEN) ? CORDIC_STEPS : ANG_TAB_LEN;

    // Square root cells, one per result bit (the root is below 2^31).
    localparam int SQRT_CELLS = 31;

    // Widths of sums, CORDIC vectors and the angle accumulator.
    localparam int SW = 36;
    localparam int VW = 40;
    localparam int AW = 26;

    // Right angle in degrees * 65536.
    localparam logic signed [AW-1:0] ANG_90 = AW'(90 * 65536);

    // Output limits in degrees * 128.
    localparam logic signed [16:0] LIM_180 = 17'sd23040;
    localparam logic signed [16:0] LIM_90  = 17'sd11520;

    // One vector on its way through the CORDIC chain.
    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic signed [AW-1:0] z;
        logic                 zero;
    } vec_t;

    // One beat in the CORDIC chain: three angles and the clamp flag.
    typedef struct packed {
        vec_t roll;
        vec_t pitch;
        vec_t yaw;
        logic clamped;
    } cord_t;

    // One beat in the square root chain.
    typedef struct packed {
        logic signed [SW-1:0] rn;
        logic signed [SW-1:0] rd;
        logic signed [SW-1:0] yn;
        logic signed [SW-1:0] yd;
        logic signed [31:0]   t;
        logic                 clamped;
        logic [63:0]          rem;
        logic [63:0]          root;
    } sqrt_t;

    // atan(2^-i) in degrees * 65536.
    function automatic logic signed [AW-1:0] ang_of(input logic [4:0] i);
        logic signed [AW-1:0] a;
        case (i)
            5'd0:    a = 26'sd2949120;
            5'd1:    a = 26'sd1740967;
            5'd2:    a = 26'sd919879;
            5'd3:    a = 26'sd466945;
            5'd4:    a = 26'sd234379;
            5'd5:    a = 26'sd117304;
            5'd6:    a = 26'sd58666;
            5'd7:    a = 26'sd29335;
            5'd8:    a = 26'sd14668;
            5'd9:    a = 26'sd7334;
            5'd10:   a = 26'sd3667;
            5'd11:   a = 26'sd1833;
            5'd12:   a = 26'sd917;
            5'd13:   a = 26'sd458;
            5'd14:   a = 26'sd229;
            5'd15:   a = 26'sd115;
            5'd16:   a = 26'sd57;
            5'd17:   a = 26'sd29;
            5'd18:   a = 26'sd14;
            5'd19:   a = 26'sd7;
            5'd20:   a = 26'sd4;
            5'd21:   a = 26'sd2;
            5'd22:   a = 26'sd1;
            default: a = 26'sd0;
        endcase
        return a;
    endfunction

    // Degrees * 65536 to degrees * 128, nearest with ties upward, saturated.
    function automatic logic signed [16:0] to_q7(input logic signed [AW-1:0] a,
                                                 input logic zero,
                                                 input logic signed [16:0] lim);
        logic signed [AW-1:0] b;
        logic signed [16:0]   r;
        b = a + AW'(256);
        r = 17'(b >>> 9);
        if (zero) begin
            r = '0;
        end else if (r > lim) begin
            r = lim;
        end else if (r < -lim) begin
            r = -lim;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* rtl/qte_sqrt_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// qte_sqrt_cell: one bit of the square root chain
// Decides one result bit of the restoring square root and passes the beat on.
// ----------------------------------------------------------------------------
module qte_sqrt_cell
    import qte_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       en,
    input  wire logic [4:0] step,
    input  wire logic       valid_in,
    input  wire sqrt_t      data_in,
    output logic            valid_out,
    output sqrt_t           data_out
);

    logic  valid_reg;
    sqrt_t data_reg;
    sqrt_t data_next;

    // Trial subtraction of root plus the current power of four.
    always_comb
    begin
        logic [63:0] bitv;
        logic [63:0] trial;
        bitv      = 64'd1 << {step, 1'b0};
        trial     = data_in.root + bitv;
        data_next = data_in;
        if (data_in.rem >= trial) begin
            data_next.rem  = data_in.rem - trial;
            data_next.root = (data_in.root >> 1) + bitv;
        end else begin
            data_next.root = data_in.root >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule
`default_nettype wire

/* rtl/qte_cordic_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// qte_cordic_cell: one CORDIC rotation for the three angles
// Rotates the roll, pitch and yaw vectors towards the x axis by atan(2^-step).
// ----------------------------------------------------------------------------
module qte_cordic_cell
    import qte_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       en,
    input  wire logic [4:0] step,
    input  wire logic       valid_in,
    input  wire cord_t      data_in,
    output logic            valid_out,
    output cord_t           data_out
);

    logic  valid_reg;
    cord_t data_reg;
    cord_t data_next;

    function automatic vec_t rot(input vec_t v, input logic [4:0] i);
        vec_t                 r;
        logic signed [VW-1:0] dx;
        logic signed [VW-1:0] dy;
        dx = v.y >>> i;
        dy = v.x >>> i;
        r  = v;
        if (!v.y[VW-1]) begin
            r.x = v.x + dx;
            r.y = v.y - dy;
            r.z = v.z + ang_of(i);
        end else begin
            r.x = v.x - dx;
            r.y = v.y + dy;
            r.z = v.z - ang_of(i);
        end
        return r;
    endfunction

    // One rotation in each of the three lanes.
    always_comb
    begin
        data_next.roll    = rot(data_in.roll, step);
        data_next.pitch   = rot(data_in.pitch, step);
        data_next.yaw     = rot(data_in.yaw, step);
        data_next.clamped = data_in.clamped;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule
`default_nettype wire

/* rtl/quaternion_to_euler_angles_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_unit: quaternion to roll, pitch and yaw
// Products, sums and clamp, a bit-per-cell square root chain and a chain of
// CORDIC cells that turn three vectors into angles in degrees * 128.
// ----------------------------------------------------------------------------
// Path from input beat to output beat: product, sum and radicand registers, the 31
// square root cells, the start vector register, the CORDIC cells and the output register.
// Throughput: one beat per cycle; the whole chain moves when the output
// register is empty or being taken.
// Reset: all valid bits clear and frame_mode returns to 1 (robot frame).
module quaternion_to_euler_angles_unit
    import qte_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic               cfg_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [15:0] quat_x,
    input  wire logic signed [15:0] quat_y,
    input  wire logic signed [15:0] quat_z,
    input  wire logic signed [15:0] quat_w,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [15:0]      roll_deg,
    output logic signed [14:0]      pitch_deg,
    output logic signed [15:0]      yaw_deg,
    output logic                    pitch_clamped
);

    logic en;
    logic frame_mode_reg;

    // Product stage.
    logic               pv_reg;
    logic signed [31:0] xx_reg, yy_reg, zz_reg, ww_reg, xy_reg;
    logic signed [31:0] xz_reg, xw_reg, yz_reg, yw_reg, zw_reg;

    // Sum stage.
    logic                 sv_reg;
    logic signed [SW-1:0] rn_reg, rd_reg, yn_reg, yd_reg;
    logic signed [31:0]   t_reg;
    logic                 clamped_reg;
    logic signed [SW-1:0] rn_next, rd_next, yn_next, yd_next, t_wide;
    logic signed [31:0]   t_next;
    logic                 clamped_next;

    // Square root chain.
    logic  sq_valid [0:SQRT_CELLS];
    sqrt_t sq_data  [0:SQRT_CELLS];
    sqrt_t sq_first_reg;
    logic  sq_first_valid_reg;

    // CORDIC chain.
    logic  cv      [0:N_ITER];
    cord_t cd      [0:N_ITER];
    cord_t pre_reg;
    cord_t pre_next;
    logic  pre_valid_reg;

    // Output register.
    logic               out_valid_reg;
    logic signed [15:0] roll_reg;
    logic signed [14:0] pitch_reg;
    logic signed [15:0] yaw_reg;
    logic               clamped_out_reg;

    assign en        = !out_valid_reg || out_ready;
    assign in_ready  = en;
    assign cfg_ready = 1'b1;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            frame_mode_reg <= 1'b1;
        end else if (cfg_valid) begin
            frame_mode_reg <= cfg_data;
        end
    end

    // Valid bits of the stages held in the top level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pv_reg             <= 1'b0;
            sv_reg             <= 1'b0;
            sq_first_valid_reg <= 1'b0;
            pre_valid_reg      <= 1'b0;
            out_valid_reg      <= 1'b0;
        end else if (en) begin
            pv_reg             <= in_valid;
            sv_reg             <= pv_reg;
            sq_first_valid_reg <= sv_reg;
            pre_valid_reg      <= sq_valid[SQRT_CELLS];
            out_valid_reg      <= cv[N_ITER];
        end
    end

    // All products of two components.
    always_ff @(posedge clk)
    begin
        if (en) begin
            xx_reg <= quat_x * quat_x;
            yy_reg <= quat_y * quat_y;
            zz_reg <= quat_z * quat_z;
            ww_reg <= quat_w * quat_w;
            xy_reg <= quat_x * quat_y;
            xz_reg <= quat_x * quat_z;
            xw_reg <= quat_x * quat_w;
            yz_reg <= quat_y * quat_z;
            yw_reg <= quat_y * quat_w;
            zw_reg <= quat_z * quat_w;
        end
    end

    // Quadratic forms for the chosen frame, and the clamp of the sine term.
    always_comb
    begin
        logic signed [SW-1:0] exx, eyy, ezz, eww, exy, exz, exw, eyz, eyw, ezw;
        exx = xx_reg;
        eyy = yy_reg;
        ezz = zz_reg;
        eww = ww_reg;
        exy = xy_reg;
        exz = xz_reg;
        exw = xw_reg;
        eyz = yz_reg;
        eyw = yw_reg;
        ezw = zw_reg;
        if (!frame_mode_reg) begin
            rn_next = (eyz + exw) <<< 1;
            rd_next = eww + ezz - eyy - exx;
            t_wide  = (eyw - exz) <<< 1;
            yn_next = (exy + ezw) <<< 1;
            yd_next = eww + exx - eyy - ezz;
        end else begin
            rn_next = (-exy - ezw) <<< 1;
            rd_next = eww + eyy - exx - ezz;
            t_wide  = (eyz - exw) <<< 1;
            yn_next = (exz + eyw) <<< 1;
            yd_next = eww + ezz - exx - eyy;
        end
        clamped_next = 1'b0;
        t_next       = 32'(t_wide);
        if (t_wide > SW'(64'sd1 << 30)) begin
            t_next       = 32'sd1 << 30;
            clamped_next = 1'b1;
        end else if (t_wide < -SW'(64'sd1 << 30)) begin
            t_next       = -(32'sd1 << 30);
            clamped_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            rn_reg      <= rn_next;
            rd_reg      <= rd_next;
            yn_reg      <= yn_next;
            yd_reg      <= yd_next;
            t_reg       <= t_next;
            clamped_reg <= clamped_next;
        end
    end

    // Radicand of the cosine term: one minus the square of the sine term.
    always_ff @(posedge clk)
    begin
        logic signed [63:0] tsq;
        tsq = t_reg * t_reg;
        if (en) begin
            sq_first_reg.rn      <= rn_reg;
            sq_first_reg.rd      <= rd_reg;
            sq_first_reg.yn      <= yn_reg;
            sq_first_reg.yd      <= yd_reg;
            sq_first_reg.t       <= t_reg;
            sq_first_reg.clamped <= clamped_reg;
            sq_first_reg.rem     <= (64'd1 << 60) - 64'(tsq);
            sq_first_reg.root    <= '0;
        end
    end

    assign sq_valid[0] = sq_first_valid_reg;
    assign sq_data[0]  = sq_first_reg;

    // Square root chain, most significant result bit first.
    for (genvar j = 0; j < SQRT_CELLS; j++) begin : g_sqrt
        qte_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .step      (5'(SQRT_CELLS - 1 - j)),
            .valid_in  (sq_valid[j]),
            .data_in   (sq_data[j]),
            .valid_out (sq_valid[j+1]),
            .data_out  (sq_data[j+1])
        );
    end

    // Start vector of one atan2, turned by a right angle when x is negative.
    function automatic vec_t start_vec(input logic signed [VW-1:0] num,
                                       input logic signed [VW-1:0] den);
        vec_t v;
        v.zero = (num == '0) && (den == '0);
        v.x    = den;
        v.y    = num;
        v.z    = '0;
        if (den[VW-1]) begin
            if (!num[VW-1]) begin
                v.x = num;
                v.y = -den;
                v.z = ANG_90;
            end else begin
                v.x = -num;
                v.y = den;
                v.z = -ANG_90;
            end
        end
        return v;
    endfunction

    always_comb
    begin
        sqrt_t s;
        s = sq_data[SQRT_CELLS];
        pre_next.roll    = start_vec(VW'(s.rn), VW'(s.rd));
        pre_next.pitch   = start_vec(VW'(s.t), VW'(s.root[31:0]));
        pre_next.yaw     = start_vec(VW'(s.yn), VW'(s.yd));
        pre_next.clamped = s.clamped;
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            pre_reg <= pre_next;
        end
    end

    assign cv[0] = pre_valid_reg;
    assign cd[0] = pre_reg;

    // CORDIC chain, one rotation per cell.
    for (genvar k = 0; k < N_ITER; k++) begin : g_cordic
        qte_cordic_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .step      (5'(k)),
            .valid_in  (cv[k]),
            .data_in   (cd[k]),
            .valid_out (cv[k+1]),
            .data_out  (cd[k+1])
        );
    end

    // Rounding, saturation and the output register.
    always_ff @(posedge clk)
    begin
        if (en) begin
            roll_reg        <= 16'(to_q7(cd[N_ITER].roll.z, cd[N_ITER].roll.zero, LIM_180));
            pitch_reg       <= 15'(to_q7(cd[N_ITER].pitch.z, cd[N_ITER].pitch.zero, LIM_90));
            yaw_reg         <= 16'(to_q7(cd[N_ITER].yaw.z, cd[N_ITER].yaw.zero, LIM_180));
            clamped_out_reg <= cd[N_ITER].clamped;
        end
    end

    assign out_valid     = out_valid_reg;
    assign roll_deg      = roll_reg;
    assign pitch_deg     = pitch_reg;
    assign yaw_deg       = yaw_reg;
    assign pitch_clamped = clamped_out_reg;

endmodule
`default_nettype wire
